// ===== rtl/rdtpc_pkg.sv =====
// Package for the retry-driven transmit power control block.
// Holds widths, cause codes, register indexes and the structs shared by all files.
// No dependencies.
package rdtpc_pkg;

  localparam int PowW   = 6;
  localparam int CntW   = 16;
  localparam int IdxW   = 2;
  localparam int IvlW   = 3;
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [PowW-1:0] MaxPowerReset = PowW'(16);
  localparam logic [IvlW-1:0] IvlSat        = IvlW'(6);
  localparam logic [IvlW-1:0] IdleShutoff   = IvlW'(5);
  localparam logic [IvlW-1:0] BeaconLimit   = IvlW'(5);

  typedef logic [PowW-1:0] pow_t;

  typedef enum logic [IdxW-1:0] {
    REG_POWER_CAP       = 2'd0,
    REG_WEIGHTED_ENABLE = 2'd1,
    REG_BEACON_ENABLE   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    CAUSE_ADAPT  = 2'd0,
    CAUSE_IDLE   = 2'd1,
    CAUSE_BEACON = 2'd2
  } cause_t;

  typedef struct packed {
    pow_t power_cap;
    logic weighted_enable;
    logic beacon_enable;
  } cfg_t;

  typedef struct packed {
    logic active;
    logic up;
    logic heavy;
  } class_t;

  typedef struct packed {
    pow_t   power_level;
    cause_t cause;
    logic   last;
  } res_t;

endpackage

// ===== rtl/rdtpc_if.sv =====
// Channel interfaces of the transmit power control block.
// Depends on rdtpc_pkg for field widths.
interface rdtpc_in_if;
  logic                        valid;
  logic                        ready;
  logic [rdtpc_pkg::CntW-1:0]  sent_count;
  logic [rdtpc_pkg::CntW-1:0]  retry_count;

  modport source (output valid, output sent_count, output retry_count, input ready);
  modport sink   (input valid, input sent_count, input retry_count, output ready);
endinterface

interface rdtpc_out_if;
  logic                        valid;
  logic                        ready;
  logic [rdtpc_pkg::PowW-1:0]  power_level;
  logic [1:0]                  cause;
  logic                        last;

  modport source (output valid, output power_level, output cause, output last, input ready);
  modport sink   (input valid, input power_level, input cause, input last, output ready);
endinterface

// ===== rtl/rdtpc_front.sv =====
// Front end: classifies one interval's sent and retry counts.
// Depends on rdtpc_pkg.
module rdtpc_front (
  input  logic [rdtpc_pkg::CntW-1:0] sent_count,
  input  logic [rdtpc_pkg::CntW-1:0] retry_count,
  output rdtpc_pkg::class_t          cls
);

  logic [rdtpc_pkg::CntW+3:0] retry_x10;
  logic [rdtpc_pkg::CntW+2:0] sent_x5;

  assign retry_x10 = {1'b0, retry_count, 3'b0} + {3'b0, retry_count, 1'b0};
  assign sent_x5   = {1'b0, sent_count, 2'b0} + {3'b0, sent_count};

  always_comb begin
    cls.active = (sent_count != '0) || (retry_count != '0);
    cls.up     = retry_x10 >= {4'b0, sent_count};
    cls.heavy  = (sent_count != '0) &&
                 ({3'b0, retry_count} >= sent_x5);
  end

endmodule

// ===== rtl/rdtpc_queue.sv =====
// Short queue of classified intervals between front and back end.
// Depends on rdtpc_pkg.
module rdtpc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rdtpc_pkg::class_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output rdtpc_pkg::class_t head
);

  rdtpc_pkg::class_t             mem_r [rdtpc_pkg::QDepth];
  logic [rdtpc_pkg::QPtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [rdtpc_pkg::QPtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [rdtpc_pkg::QCntW-1:0]   count_r, count_nxt;

  localparam logic [rdtpc_pkg::QPtrW-1:0] LastPtr = rdtpc_pkg::QPtrW'(rdtpc_pkg::QDepth - 1);
  localparam logic [rdtpc_pkg::QCntW-1:0] FullCnt = rdtpc_pkg::QCntW'(rdtpc_pkg::QDepth);

  assign full      = (count_r == FullCnt);
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/rdtpc_back.sv =====
// Back end: power state update, idle and beacon counters, result output stage.
// Depends on rdtpc_pkg.
module rdtpc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  rdtpc_pkg::cfg_t   cfg,
  input  logic              q_valid,
  input  rdtpc_pkg::class_t q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output rdtpc_pkg::res_t   out_res
);

  rdtpc_pkg::pow_t              cur_pow_r, cur_pow_nxt;
  rdtpc_pkg::pow_t              step_r, step_nxt;
  logic [rdtpc_pkg::IvlW-1:0]   idle_r, idle_nxt;
  logic [rdtpc_pkg::IvlW-1:0]   bcn_r, bcn_nxt;
  logic                         out_v_r, out_v_nxt;
  rdtpc_pkg::res_t              out_res_r, out_res_nxt;
  logic                         pend_v_r, pend_v_nxt;
  rdtpc_pkg::pow_t              pend_pow_r, pend_pow_nxt;

  logic [rdtpc_pkg::PowW+1:0]   step_x4;
  rdtpc_pkg::pow_t              step_q, step_half, inc;
  logic [rdtpc_pkg::PowW:0]     sum;
  logic                         moved, fire, out_free;
  logic                         r0_v, r1_v;
  rdtpc_pkg::res_t              r0;

  assign out_free  = !out_v_r || out_ready;
  assign q_pop     = q_valid && !pend_v_r && out_free;
  assign out_valid = out_v_r;
  assign out_res   = out_res_r;

  always_comb begin
    step_x4     = {step_r, 2'b0};
    step_q      = step_r;
    if (cfg.weighted_enable && q_head.heavy) begin
      step_q = (step_x4 > {2'b0, cfg.power_cap}) ? cfg.power_cap
                                                 : step_x4[rdtpc_pkg::PowW-1:0];
    end
    step_half   = step_q >> 1;
    if (step_half == '0) begin
      step_half = rdtpc_pkg::PowW'(1);
    end
    inc         = cfg.weighted_enable ? step_half : rdtpc_pkg::PowW'(1);
    sum         = {1'b0, cur_pow_r} + {1'b0, inc};

    cur_pow_nxt = cur_pow_r;
    step_nxt    = step_r;
    idle_nxt    = idle_r;
    moved       = 1'b0;
    r0_v        = 1'b0;
    r0          = '{power_level: '0, cause: rdtpc_pkg::CAUSE_ADAPT, last: 1'b1};

    if (q_head.active) begin
      idle_nxt = '0;
      if (q_head.up) begin
        moved = (cur_pow_r != cfg.power_cap);
        if (moved) begin
          cur_pow_nxt = (sum > {1'b0, cfg.power_cap}) ? cfg.power_cap
                                                      : sum[rdtpc_pkg::PowW-1:0];
        end
      end else begin
        moved = (cur_pow_r != '0);
        if (moved) begin
          cur_pow_nxt = (inc > cur_pow_r) ? '0 : cur_pow_r - inc;
        end
      end
      step_nxt          = (moved && cfg.weighted_enable) ? step_half : step_q;
      r0_v              = moved;
      r0.power_level    = cur_pow_nxt;
    end else begin
      if (idle_r < rdtpc_pkg::IvlSat) begin
        idle_nxt = idle_r + 1'b1;
      end
      r0_v     = (idle_nxt == rdtpc_pkg::IdleShutoff);
      r0.cause = rdtpc_pkg::CAUSE_IDLE;
    end

    fire    = cfg.beacon_enable && (bcn_r > rdtpc_pkg::BeaconLimit);
    r1_v    = fire && (cur_pow_nxt != cfg.power_cap);
    bcn_nxt = bcn_r;
    if (fire) begin
      bcn_nxt = '0;
    end else if (bcn_r < rdtpc_pkg::IvlSat) begin
      bcn_nxt = bcn_r + 1'b1;
    end
    r0.last = !r1_v;
  end

  always_comb begin
    out_v_nxt    = out_v_r;
    out_res_nxt  = out_res_r;
    pend_v_nxt   = pend_v_r;
    pend_pow_nxt = pend_pow_r;
    if (out_free) begin
      out_v_nxt = 1'b0;
      if (pend_v_r) begin
        out_v_nxt   = 1'b1;
        out_res_nxt = '{power_level: pend_pow_r, cause: rdtpc_pkg::CAUSE_BEACON, last: 1'b1};
        pend_v_nxt  = 1'b0;
      end else if (q_pop && (r0_v || r1_v)) begin
        out_v_nxt    = 1'b1;
        out_res_nxt  = r0_v ? r0 : '{power_level: cfg.power_cap,
                                     cause: rdtpc_pkg::CAUSE_BEACON, last: 1'b1};
        pend_v_nxt   = r0_v && r1_v;
        pend_pow_nxt = cfg.power_cap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_pow_r <= rdtpc_pkg::MaxPowerReset;
      step_r    <= rdtpc_pkg::MaxPowerReset;
      idle_r    <= '0;
      bcn_r     <= '0;
      out_v_r   <= 1'b0;
      pend_v_r  <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_pow_r <= cur_pow_nxt;
        step_r    <= step_nxt;
        idle_r    <= idle_nxt;
        bcn_r     <= bcn_nxt;
      end
      out_v_r  <= out_v_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    pend_pow_r <= pend_pow_nxt;
  end

endmodule

// ===== rtl/retry_driven_tx_power_control.sv =====
// Top level of the retry-driven transmit power control block.
// Depends on rdtpc_pkg, rdtpc_if, rdtpc_front, rdtpc_queue and rdtpc_back.
//
//   channel | direction | transaction payload
//   in_ch   | sink      | sent_count[15:0], retry_count[15:0]
//   out_ch  | source    | power_level[5:0], cause[1:0], last
//   cfg_*   | write     | cfg_index[1:0], cfg_wdata[5:0]
//
// An interval enters the two-entry queue at its accepting edge; the edge at which the
// back end retires it loads its first result into the output register. One interval is
// retired a cycle while no beacon result is pending and the output is not stalled. An
// interval with an adaptive or idle result and a beacon result holds the back end while
// the second result waits in the pending register; a stalled output holds it too.
// Reset is synchronous; in_ch.ready drops only while the queue is full.
module retry_driven_tx_power_control (
  input  logic                         clk,
  input  logic                         rst_n,
  rdtpc_in_if.sink                     in_ch,
  rdtpc_out_if.source                  out_ch,
  input  logic                         cfg_we,
  input  logic [rdtpc_pkg::IdxW-1:0]   cfg_index,
  input  logic [rdtpc_pkg::PowW-1:0]   cfg_wdata
);

  rdtpc_pkg::cfg_t    cfg_r;
  rdtpc_pkg::class_t  cls, q_head;
  rdtpc_pkg::res_t    res;
  logic               q_full, q_valid, q_pop, push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{power_cap: rdtpc_pkg::MaxPowerReset, weighted_enable: 1'b0,
                 beacon_enable: 1'b0};
    end else if (cfg_we) begin
      case (cfg_index)
        rdtpc_pkg::REG_POWER_CAP:       cfg_r.power_cap       <= cfg_wdata;
        rdtpc_pkg::REG_WEIGHTED_ENABLE: cfg_r.weighted_enable <= cfg_wdata[0];
        rdtpc_pkg::REG_BEACON_ENABLE:   cfg_r.beacon_enable   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  rdtpc_front u_front (
    .sent_count  (in_ch.sent_count),
    .retry_count (in_ch.retry_count),
    .cls         (cls)
  );

  rdtpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (cls),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  rdtpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  assign out_ch.power_level = res.power_level;
  assign out_ch.cause       = res.cause;
  assign out_ch.last        = res.last;

endmodule

// ===== rtl/rdtpc_checker.sv =====
// Port-level checks for the transmit power control block, bound to the top level.
// Depends on rdtpc_pkg and retry_driven_tx_power_control.
module rdtpc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rdtpc_pkg::PowW-1:0]  out_power_level,
  input logic [1:0]                  out_cause,
  input logic                        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_power_level) &&
                                $stable(out_cause) && $stable(out_last))
    else $error("result changed while stalled");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cause == rdtpc_pkg::CAUSE_IDLE |-> out_power_level == '0)
    else $error("idle shutoff with nonzero power");

  a_beacon_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cause == rdtpc_pkg::CAUSE_BEACON |-> out_last)
    else $error("beacon result not final");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind retry_driven_tx_power_control rdtpc_checker u_rdtpc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_power_level (out_ch.power_level),
  .out_cause       (out_ch.cause),
  .out_last        (out_ch.last)
);
